>>> sv/cits_pkg.sv
// Shared types and constants for the camera/IMU trigger sequencer.
// No dependencies.
package cits_pkg;

    typedef struct packed {
        logic [2:0]  operation;
        logic [2:0]  requested_state;
        logic [19:0] sample_count;
        logic [16:0] frame_rate;
        logic [31:0] time_value;
        logic        pin_level;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] time_out;
        logic [31:0] frames_first;
        logic [31:0] frames_second;
        logic        camera_index;
        logic [1:0]  current_state;
        logic [2:0]  error_code;
        logic        last;
    } out_item_t;

    localparam logic [2:0] OP_REQ  = 3'd0;
    localparam logic [2:0] OP_IMU  = 3'd1;
    localparam logic [2:0] OP_CAM1 = 3'd2;
    localparam logic [2:0] OP_CAM2 = 3'd3;
    localparam logic [2:0] OP_TRIG = 3'd4;

    localparam logic [1:0] ST_STOP    = 2'd0;
    localparam logic [1:0] ST_CAL_IMU = 2'd1;
    localparam logic [1:0] ST_CAL_CAM = 2'd2;
    localparam logic [1:0] ST_RUN     = 2'd3;

    localparam logic [2:0] K_ACK      = 3'd0;
    localparam logic [2:0] K_IMU_TS   = 3'd1;
    localparam logic [2:0] K_IMU_SMP  = 3'd2;
    localparam logic [2:0] K_CAM_TS   = 3'd3;
    localparam logic [2:0] K_IMU_DONE = 3'd4;
    localparam logic [2:0] K_CAM_DONE = 3'd5;
    localparam logic [2:0] K_CMP      = 3'd6;
    localparam logic [2:0] K_ERR      = 3'd7;

    localparam logic [2:0] E_BAD_STATE = 3'd0;
    localparam logic [2:0] E_ILLEGAL   = 3'd1;
    localparam logic [2:0] E_CAM1      = 3'd2;
    localparam logic [2:0] E_CAM2      = 3'd3;
    localparam logic [2:0] E_ZERO_RATE = 3'd4;

    localparam logic [1:0] ADDR_PULSE_WIDTH = 2'd0;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture input item, decode
        logic div_start; // start period division
        logic mul_start; // start compare multiply
        logic finish;    // commit state and build results
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div;
        logic need_mul;
        logic div_done;
        logic mul_done;
        logic [1:0] nres;
    } dp_stat_t;

endpackage

>>> sv/camera_imu_trigger_sequencer.sv
// Camera/IMU trigger sequencer top: APB register, controller, datapath.
// Results are registered in the controller after a decode state; a camera-cal request
// first runs the serial divider, and a trigger falling edge that needs a compare runs the multiplier.
// One item at a time: a new input is taken only once all results of the last one are out.
// Reset (rst_n async low): state STOP, counters zero, pulse_width 100.
// Depends on cits_pkg, cits_control, cits_datapath.
module camera_imu_trigger_sequencer
    import cits_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] pulse_width_reg;
    dp_cmd_t     cmd;
    dp_stat_t    stat;
    out_item_t   res0, res1;

    // config: single register at byte 0
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_PULSE_WIDTH) ? {16'd0, pulse_width_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pulse_width_reg <= 16'd100;
        else if (psel && penable && pwrite && paddr == ADDR_PULSE_WIDTH)
            pulse_width_reg <= pwdata[15:0];
    end

    cits_control u_ctl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .stat(stat), .cmd(cmd), .res0(res0), .res1(res1),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
    );

    cits_datapath #(.TICKS(TICKS_PER_SECOND)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat), .item(in_data),
        .pulse_width(pulse_width_reg), .res0(res0), .res1(res1)
    );

`ifndef SYNTH
    // no new input while a result transfer is pending
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken during output");
    // divider and multiplier never started together
    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.div_start && cmd.mul_start)) else $error("both units started");
`endif

endmodule

>>> sv/cits_datapath.sv
// Datapath: sequencer state, serial divider and multiplier, result builder.
// Depends on cits_pkg.
module cits_datapath
    import cits_pkg::*;
#(
    parameter int TICKS = 1000000
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  in_item_t    item,
    input  logic [15:0] pulse_width,
    output out_item_t   res0,
    output out_item_t   res1
);

    localparam int TW = $clog2(TICKS + 1);
    localparam logic [TW-1:0] TICKS_V = TW'(TICKS);

    in_item_t    it_reg;
    logic [1:0]  board_reg;
    logic        halted_reg;
    logic [19:0] imu_count_reg, imu_target_reg, cam_target_reg, period_reg;
    logic        imu_done_reg;
    logic [31:0] origin_reg, trig_count_reg, start0_reg, start1_reg, end0_reg;
    logic [31:0] fc0_reg, fc1_reg;

    // restoring divider, one quotient bit per cycle
    logic [TW-1:0] dq_reg;
    logic [16:0]   drem_reg;
    logic [5:0]    dcnt_reg;
    logic          dbusy_reg, ddone_reg;
    logic [17:0]   dtrial;
    // shift-add multiplier, trigger_count+1 by period, one bit per cycle
    logic [31:0]   macc_reg, mcand_reg;
    logic [19:0]   mplier_reg;
    logic [4:0]    mcnt_reg;
    logic          mbusy_reg, mdone_reg;

    logic active, is_req, bad_val, illegal, zero_rate;
    logic [31:0] d_cam, comp, end_cmp;
    logic [19:0] period_sat;
    logic        cam_sel;
    logic [31:0] st_sel;
    logic        need_div_c, need_mul_c;
    logic [1:0]  nres_c;

    assign active  = board_reg[1];
    assign is_req  = (it_reg.operation == OP_REQ);
    assign bad_val = it_reg.requested_state[2];
    assign illegal = (it_reg.requested_state[1:0] == ST_STOP    && board_reg == ST_STOP)
                  || (it_reg.requested_state[1:0] == ST_CAL_IMU && board_reg != ST_STOP)
                  || (it_reg.requested_state[1:0] == ST_CAL_CAM && board_reg != ST_CAL_IMU)
                  || (it_reg.requested_state[1:0] == ST_RUN     && board_reg != ST_CAL_CAM);
    assign zero_rate = (it_reg.requested_state[1:0] == ST_CAL_CAM) && (it_reg.frame_rate == '0);
    assign cam_sel = it_reg.operation[0];
    assign st_sel  = cam_sel ? start1_reg : start0_reg;
    assign d_cam   = it_reg.time_value - st_sel;
    assign dtrial  = {drem_reg, dq_reg[TW-1]} - {1'b0, it_reg.frame_rate};
    assign period_sat = (dq_reg > TW'(20'hFFFFF)) ? 20'hFFFFF : 20'(dq_reg);

    always_comb
    begin
        logic [31:0] d;
        d = end0_reg - start0_reg;
        comp = '0;
        if (fc0_reg != '0 && !d[31])
            comp = {1'b0, d[31:1]};
    end
    assign end_cmp = origin_reg + macc_reg - comp;

    assign need_div_c = !halted_reg && is_req && !bad_val && !illegal && !zero_rate
                     && it_reg.requested_state[1:0] == ST_CAL_CAM;
    assign need_mul_c = !halted_reg && it_reg.operation == OP_TRIG && !it_reg.pin_level
                     && active && ({12'd0, cam_target_reg} > fc1_reg + 32'd1);

    always_comb
    begin
        stat.need_div = need_div_c;
        stat.need_mul = need_mul_c;
        stat.div_done = ddone_reg;
        stat.mul_done = mdone_reg;
        stat.nres     = nres_c;
    end

    // result build (combinational from loaded item and current state)
    always_comb
    begin
        out_item_t r0, r1;
        logic [1:0] n;
        logic [1:0] ns;
        r0 = '0; r1 = '0; n = 2'd0; ns = board_reg;
        if (!halted_reg)
        begin
            case (it_reg.operation)
                OP_REQ:
                begin
                    n = 2'd1;
                    r0.kind = K_ERR;
                    if (bad_val) r0.error_code = E_BAD_STATE;
                    else if (illegal) r0.error_code = E_ILLEGAL;
                    else if (zero_rate) r0.error_code = E_ZERO_RATE;
                    else
                    begin
                        r0.kind = K_ACK;
                        ns = it_reg.requested_state[1:0];
                        if (ns == ST_CAL_IMU && imu_count_reg == it_reg.sample_count)
                        begin
                            n = 2'd2; r1.kind = K_IMU_DONE;
                        end
                        else if (ns == ST_CAL_CAM)
                        begin
                            n = 2'd2; r1.kind = K_CMP;
                            r1.time_out = it_reg.time_value + {12'd0, period_sat};
                        end
                    end
                end
                OP_IMU:
                begin
                    if (board_reg == ST_CAL_IMU && !imu_done_reg)
                    begin
                        n = 2'd1; r0.kind = K_IMU_TS; r0.time_out = it_reg.time_value;
                        if (imu_count_reg + 20'd1 == imu_target_reg)
                        begin
                            n = 2'd2; r1.kind = K_IMU_DONE;
                        end
                    end
                    else if (active)
                    begin
                        n = 2'd1; r0.kind = K_IMU_SMP; r0.time_out = it_reg.time_value;
                    end
                end
                OP_CAM1, OP_CAM2:
                begin
                    if (active && !it_reg.pin_level)
                    begin
                        n = 2'd1;
                        if (d_cam > {12'd0, period_reg})
                        begin
                            r0.kind = K_ERR;
                            r0.error_code = cam_sel ? E_CAM2 : E_CAM1;
                        end
                        else
                        begin
                            r0.kind = K_CAM_TS;
                            r0.time_out = st_sel + {1'b0, d_cam[31:1]};
                            r0.frames_first = (cam_sel ? fc1_reg : fc0_reg) + 32'd1;
                            r0.camera_index = cam_sel;
                            if (cam_sel && fc1_reg + 32'd1 == {12'd0, cam_target_reg})
                            begin
                                n = 2'd2; r1.kind = K_CAM_DONE;
                                r1.frames_first = fc0_reg;
                                r1.frames_second = fc1_reg + 32'd1;
                            end
                        end
                    end
                end
                OP_TRIG:
                begin
                    if (it_reg.pin_level)
                    begin
                        n = 2'd1; r0.kind = K_CMP;
                        r0.time_out = it_reg.time_value + {16'd0, pulse_width};
                    end
                    else if (need_mul_c)
                    begin
                        n = 2'd1; r0.kind = K_CMP; r0.time_out = end_cmp;
                    end
                end
                default: n = 2'd0;
            endcase
        end
        r0.current_state = ns; r1.current_state = ns;
        r0.last = (n == 2'd1); r1.last = 1'b1;
        res0 = r0; res1 = r1; nres_c = n;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load) it_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dbusy_reg <= 1'b0; ddone_reg <= 1'b0; mbusy_reg <= 1'b0; mdone_reg <= 1'b0;
            dq_reg <= '0; drem_reg <= '0; dcnt_reg <= '0;
            macc_reg <= '0; mcand_reg <= '0; mplier_reg <= '0; mcnt_reg <= '0;
        end
        else
        begin
            ddone_reg <= 1'b0;
            mdone_reg <= 1'b0;
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1; dq_reg <= TICKS_V; drem_reg <= '0;
                dcnt_reg <= 6'(TW);
            end
            else if (dbusy_reg)
            begin
                if (!dtrial[17])
                begin
                    drem_reg <= dtrial[16:0];
                    dq_reg <= {dq_reg[TW-2:0], 1'b1};
                end
                else
                begin
                    drem_reg <= {drem_reg[15:0], dq_reg[TW-1]};
                    dq_reg <= {dq_reg[TW-2:0], 1'b0};
                end
                dcnt_reg <= dcnt_reg - 6'd1;
                if (dcnt_reg == 6'd1)
                begin
                    dbusy_reg <= 1'b0; ddone_reg <= 1'b1;
                end
            end
            if (cmd.mul_start)
            begin
                mbusy_reg <= 1'b1; macc_reg <= '0;
                mcand_reg <= trig_count_reg + 32'd1; mplier_reg <= period_reg;
                mcnt_reg <= 5'd20;
            end
            else if (mbusy_reg)
            begin
                if (mplier_reg[0]) macc_reg <= macc_reg + mcand_reg;
                mcand_reg <= {mcand_reg[30:0], 1'b0};
                mplier_reg <= {1'b0, mplier_reg[19:1]};
                mcnt_reg <= mcnt_reg - 5'd1;
                if (mcnt_reg == 5'd1)
                begin
                    mbusy_reg <= 1'b0; mdone_reg <= 1'b1;
                end
            end
        end
    end

    // state commit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_reg <= ST_STOP; halted_reg <= 1'b0;
            imu_count_reg <= '0; imu_target_reg <= '0; imu_done_reg <= 1'b0;
            cam_target_reg <= '0; period_reg <= '0; origin_reg <= '0;
            trig_count_reg <= '0; start0_reg <= '0; start1_reg <= '0;
            end0_reg <= '0; fc0_reg <= '0; fc1_reg <= '0;
        end
        else if (cmd.finish)
        begin
            board_reg <= res0.current_state;
            if (stat.nres != 2'd0 && res0.kind == K_ERR) halted_reg <= 1'b1;
            if (!halted_reg)
            begin
                case (it_reg.operation)
                    OP_REQ:
                    begin
                        if (res0.kind == K_ACK)
                        begin
                            case (it_reg.requested_state[1:0])
                                ST_STOP:
                                begin
                                    imu_count_reg <= '0; imu_done_reg <= 1'b0;
                                    fc0_reg <= '0; fc1_reg <= '0;
                                end
                                ST_CAL_IMU:
                                begin
                                    imu_target_reg <= it_reg.sample_count;
                                    if (imu_count_reg == it_reg.sample_count)
                                        imu_done_reg <= 1'b1;
                                end
                                ST_CAL_CAM:
                                begin
                                    cam_target_reg <= it_reg.sample_count;
                                    period_reg <= period_sat;
                                    origin_reg <= it_reg.time_value;
                                end
                                default: ;
                            endcase
                        end
                    end
                    OP_IMU:
                    begin
                        if (res0.kind == K_IMU_TS && stat.nres != 2'd0)
                        begin
                            imu_count_reg <= imu_count_reg + 20'd1;
                            if (stat.nres == 2'd2) imu_done_reg <= 1'b1;
                        end
                    end
                    OP_CAM1, OP_CAM2:
                    begin
                        if (active)
                        begin
                            if (it_reg.pin_level)
                            begin
                                if (cam_sel) start1_reg <= it_reg.time_value;
                                else start0_reg <= it_reg.time_value;
                            end
                            else if (res0.kind == K_CAM_TS)
                            begin
                                if (cam_sel) fc1_reg <= fc1_reg + 32'd1;
                                else
                                begin
                                    fc0_reg <= fc0_reg + 32'd1;
                                    end0_reg <= it_reg.time_value;
                                end
                            end
                        end
                    end
                    OP_TRIG:
                        if (it_reg.pin_level) trig_count_reg <= trig_count_reg + 32'd1;
                    default: ;
                endcase
            end
        end
    end

endmodule

>>> sv/cits_control.sv
// Controller: sequences load, divide/multiply and result transfers.
// Depends on cits_pkg.
module cits_control
    import cits_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dp_stat_t  stat,
    output dp_cmd_t   cmd,
    input  out_item_t res0,
    input  out_item_t res1,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    typedef enum logic [2:0] {S_IDLE, S_DEC, S_DIV, S_MUL, S_OUT0, S_OUT1} state_t;

    state_t    state_reg;
    out_item_t hold_reg;
    out_item_t hold1_reg;
    logic      valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;
    assign out_data  = hold_reg;

    always_comb
    begin
        cmd.load      = in_valid && in_ready;
        cmd.div_start = (state_reg == S_DEC) && stat.need_div;
        cmd.mul_start = (state_reg == S_DEC) && stat.need_mul;
        cmd.finish    = 1'b0;
        if (state_reg == S_DEC && !stat.need_div && !stat.need_mul) cmd.finish = 1'b1;
        if (state_reg == S_DIV && stat.div_done) cmd.finish = 1'b1;
        if (state_reg == S_MUL && stat.mul_done) cmd.finish = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            hold_reg  <= '0;
            hold1_reg <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE: if (cmd.load) state_reg <= S_DEC;
                S_DEC, S_DIV, S_MUL:
                begin
                    if (cmd.div_start) state_reg <= S_DIV;
                    else if (cmd.mul_start) state_reg <= S_MUL;
                    else if (cmd.finish)
                    begin
                        if (stat.nres == 2'd0) state_reg <= S_IDLE;
                        else
                        begin
                            // both results built from pre-commit state
                            valid_reg <= 1'b1;
                            hold_reg  <= res0;
                            hold1_reg <= res1;
                            state_reg <= (stat.nres == 2'd2) ? S_OUT1 : S_OUT0;
                        end
                    end
                end
                S_OUT1:
                    if (out_ready)
                    begin
                        hold_reg  <= hold1_reg;
                        state_reg <= S_OUT0;
                    end
                S_OUT0:
                    if (out_ready)
                    begin
                        valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

>>> test/camera_imu_trigger_sequencer_test.sv
// Self-checking testbench for camera_imu_trigger_sequencer: random and directed
// state/trigger/exposure sequences, a per-transfer predictor and APB register writes.
// Depends on cits_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module camera_imu_trigger_sequencer_test;
    import cits_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int PHASE_ITEMS    = 500;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    in_item_t    in_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    out_item_t   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    camera_imu_trigger_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    // Stimulus and result bookkeeping
    in_item_t  pending_items[$];
    out_item_t expected_results[$];
    int        sender_idle_pct = 0;
    int        receiver_idle_pct = 0;
    int        mismatch_count = 0;
    int        items_sent = 0;
    int        results_seen = 0;
    int        idle_cycles = 0;
    int        phase_pushed = 0;
    logic [31:0] stim_clock = '0;

    // Predictor copy of the sequencer state
    logic [15:0] pulse_len = 16'd100;
    logic [1:0]  board_st = ST_STOP;
    logic        stopped_by_error = 1'b0;
    logic [19:0] imu_seen = '0;
    logic [19:0] imu_goal = '0;
    logic        imu_finished = 1'b0;
    logic [19:0] cam_goal = '0;
    logic [19:0] period_ticks = '0;
    logic [31:0] origin_time = '0;
    logic [31:0] triggers = '0;
    logic [31:0] expo_start [2] = '{default: '0};
    logic [31:0] expo_end_cam1 = '0;
    logic [31:0] frames [2] = '{default: '0};

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_item_t make_result(logic [2:0] kind, logic [31:0] t,
                                              logic [31:0] f1, logic [31:0] f2,
                                              logic cam, logic [2:0] err);
        out_item_t r;
        r = '0;
        r.kind = kind;
        r.time_out = t;
        r.frames_first = f1;
        r.frames_second = f2;
        r.camera_index = cam;
        r.error_code = err;
        return r;
    endfunction

    // Works out the results of one accepted transfer and queues them.
    function automatic void predict_sequencer(in_item_t it);
        out_item_t   res[$];
        logic [2:0]  req;
        logic [31:0] d;
        logic [31:0] comp;
        logic        active;
        int          ci;
        if (stopped_by_error)
            return;
        active = (board_st == ST_CAL_CAM) || (board_st == ST_RUN);
        req = it.requested_state;
        case (it.operation)
            OP_REQ:
            begin
                if (req > 3'd3)
                begin
                    res.push_back(make_result(K_ERR, '0, '0, '0, '0, E_BAD_STATE));
                    stopped_by_error = 1'b1;
                end
                else if ((req[1:0] == ST_STOP && board_st == ST_STOP) ||
                         (req[1:0] == ST_CAL_IMU && board_st != ST_STOP) ||
                         (req[1:0] == ST_CAL_CAM && board_st != ST_CAL_IMU) ||
                         (req[1:0] == ST_RUN && board_st != ST_CAL_CAM))
                begin
                    res.push_back(make_result(K_ERR, '0, '0, '0, '0, E_ILLEGAL));
                    stopped_by_error = 1'b1;
                end
                else if (req[1:0] == ST_CAL_CAM && it.frame_rate == '0)
                begin
                    res.push_back(make_result(K_ERR, '0, '0, '0, '0, E_ZERO_RATE));
                    stopped_by_error = 1'b1;
                end
                else
                begin
                    board_st = req[1:0];
                    res.push_back(make_result(K_ACK, '0, '0, '0, '0, '0));
                    if (req[1:0] == ST_STOP)
                    begin
                        imu_seen = '0;
                        imu_finished = 1'b0;
                        frames[0] = '0;
                        frames[1] = '0;
                    end
                    else if (req[1:0] == ST_CAL_IMU)
                    begin
                        imu_goal = it.sample_count;
                        if (imu_seen == imu_goal)
                        begin
                            imu_finished = 1'b1;
                            res.push_back(make_result(K_IMU_DONE, '0, '0, '0, '0, '0));
                        end
                    end
                    else if (req[1:0] == ST_CAL_CAM)
                    begin
                        cam_goal = it.sample_count;
                        period_ticks = 20'(32'd1000000 / {15'd0, it.frame_rate});
                        origin_time = it.time_value;
                        res.push_back(make_result(K_CMP, origin_time + {12'd0, period_ticks},
                                                  '0, '0, '0, '0));
                    end
                end
            end
            OP_IMU:
            begin
                if (board_st == ST_CAL_IMU && !imu_finished)
                begin
                    res.push_back(make_result(K_IMU_TS, it.time_value, '0, '0, '0, '0));
                    imu_seen = imu_seen + 20'd1;
                    if (imu_seen == imu_goal)
                    begin
                        imu_finished = 1'b1;
                        res.push_back(make_result(K_IMU_DONE, '0, '0, '0, '0, '0));
                    end
                end
                else if (active)
                begin
                    res.push_back(make_result(K_IMU_SMP, it.time_value, '0, '0, '0, '0));
                end
            end
            OP_CAM1, OP_CAM2:
            begin
                ci = (it.operation == OP_CAM2) ? 1 : 0;
                if (active)
                begin
                    if (it.pin_level)
                    begin
                        expo_start[ci] = it.time_value;
                    end
                    else
                    begin
                        d = it.time_value - expo_start[ci];
                        if (d > {12'd0, period_ticks})
                        begin
                            res.push_back(make_result(K_ERR, '0, '0, '0, '0,
                                                      ci ? E_CAM2 : E_CAM1));
                            stopped_by_error = 1'b1;
                        end
                        else
                        begin
                            if (ci == 0)
                                expo_end_cam1 = it.time_value;
                            frames[ci] = frames[ci] + 32'd1;
                            res.push_back(make_result(K_CAM_TS, expo_start[ci] + (d >> 1),
                                                      frames[ci], '0, ci[0], '0));
                            if (ci == 1 && frames[1] == {12'd0, cam_goal})
                                res.push_back(make_result(K_CAM_DONE, '0, frames[0],
                                                          frames[1], '0, '0));
                        end
                    end
                end
            end
            OP_TRIG:
            begin
                if (it.pin_level)
                begin
                    triggers = triggers + 32'd1;
                    res.push_back(make_result(K_CMP, it.time_value + {16'd0, pulse_len},
                                              '0, '0, '0, '0));
                end
                else if (active &&
                         ({1'b0, frames[1]} + 33'd1 < {13'd0, cam_goal}))
                begin
                    // exposure compensation only once camera 1 has a frame
                    comp = '0;
                    if (frames[0] != '0)
                    begin
                        d = expo_end_cam1 - expo_start[0];
                        if (!d[31])
                            comp = d >> 1;
                    end
                    res.push_back(make_result(K_CMP, origin_time +
                                              (triggers + 32'd1) * {12'd0, period_ticks} -
                                              comp, '0, '0, '0, '0));
                end
            end
            default: ;
        endcase
        foreach (res[k])
        begin
            res[k].current_state = board_st;
            res[k].last = (k == res.size() - 1);
            expected_results.push_back(res[k]);
        end
    endfunction

    // Driver: valid stays up with a stable payload until the transfer happens
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_sequencer(in_data);
                items_sent <= items_sent + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_results.size() == 0)
                begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10)
                        $display("unexpected result: kind %0d time %h", out_data.kind,
                                 out_data.time_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.kind !== out_data.kind ||
                        want.time_out !== out_data.time_out ||
                        want.frames_first !== out_data.frames_first ||
                        want.frames_second !== out_data.frames_second ||
                        want.camera_index !== out_data.camera_index ||
                        want.current_state !== out_data.current_state ||
                        want.error_code !== out_data.error_code ||
                        want.last !== out_data.last)
                    begin
                        mismatch_count <= mismatch_count + 1;
                        if (mismatch_count < 10)
                        begin
                            $display("mismatch: expected k%0d t%h f1 %h f2 %h c%0d s%0d e%0d l%0d",
                                     want.kind, want.time_out, want.frames_first,
                                     want.frames_second, want.camera_index,
                                     want.current_state, want.error_code, want.last);
                            $display("          got      k%0d t%h f1 %h f2 %h c%0d s%0d e%0d l%0d",
                                     out_data.kind, out_data.time_out,
                                     out_data.frames_first, out_data.frames_second,
                                     out_data.camera_index, out_data.current_state,
                                     out_data.error_code, out_data.last);
                        end
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    // Watchdog: cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog expired, %0d results still expected",
                     expected_results.size());
            $display("camera_imu_trigger_sequencer_test NOT OK");
            $finish;
        end
    end

    task automatic push_item(logic [2:0] op, logic [2:0] req, logic [19:0] samples,
                             logic [16:0] rate, logic [31:0] t, logic level);
        in_item_t it;
        it.operation = op;
        it.requested_state = req;
        it.sample_count = samples;
        it.frame_rate = rate;
        it.time_value = t;
        it.pin_level = level;
        pending_items.push_back(it);
        phase_pushed++;
    endtask

    task automatic push_request(logic [1:0] st, logic [19:0] samples, logic [16:0] rate);
        stim_clock += $urandom_range(1, 3000);
        push_item(OP_REQ, {1'b0, st}, samples, rate, stim_clock, 1'($urandom_range(1)));
    endtask

    // noise: all fields random, op chosen by caller
    task automatic push_noise(logic [2:0] op);
        push_item(op, 3'($urandom), 20'($urandom), 17'($urandom), $urandom,
                  1'($urandom_range(1)));
    endtask

    task automatic push_event(logic [2:0] op, logic [31:0] t, logic level);
        push_item(op, 3'($urandom), 20'($urandom), 17'($urandom), t, level);
    endtask

    // One exposure of one camera, falling edge inside the frame period
    task automatic push_exposure(logic [2:0] op, int per);
        logic [31:0] t0;
        stim_clock += $urandom_range(1, 500);
        t0 = stim_clock;
        push_event(op, t0, 1'b1);
        push_event(op, t0 + $urandom_range(0, per), 1'b0);
    endtask

    // Well-formed STOP -> CAL_IMU -> CAL_CAM -> (RUN) -> STOP run with random content (may stop after CAL_IMU)
    task automatic push_session();
        int          per;
        int          nframes;
        bit          in_run;
        logic [16:0] rate;
        in_run = 0;
        repeat ($urandom_range(0, 2)) push_noise(3'($urandom_range(1, 7)));
        push_request(ST_CAL_IMU,
                     20'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 6)), 17'd0);
        repeat ($urandom_range(0, 8))
        begin
            if ($urandom_range(3) == 0)
                push_noise(3'($urandom_range(1, 7)));
            else
                push_event(OP_IMU, stim_clock + $urandom_range(0, 100000),
                           1'($urandom_range(1)));
        end
        if ($urandom_range(5) == 0)
        begin
            push_request(ST_STOP, 20'($urandom), 17'($urandom));
            return;
        end
        case ($urandom_range(4))
            0: rate = 17'd1;
            1: rate = 17'h1FFFF;
            2: rate = 17'($urandom_range(1, 100000));
            default: rate = 17'($urandom_range(50, 5000));
        endcase
        per = 1000000 / int'(rate);
        push_request(ST_CAL_CAM,
                     20'(($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 12)), rate);
        nframes = $urandom_range(0, 8);
        for (int f = 0; f < nframes; f++)
        begin
            stim_clock += $urandom_range(1, 2000);
            push_event(OP_TRIG, stim_clock, 1'b1);
            push_event(OP_TRIG, stim_clock + $urandom_range(1, 65535), 1'b0);
            if ($urandom_range(1))
            begin
                push_exposure(OP_CAM1, per);
                push_exposure(OP_CAM2, per);
            end
            else
            begin
                push_exposure(OP_CAM2, per);
                push_exposure(OP_CAM1, per);
            end
            if ($urandom_range(2) == 0)
                push_event(OP_IMU, $urandom, 1'($urandom_range(1)));
            if ($urandom_range(3) == 0)
                push_noise(3'($urandom_range(5, 7)));
            if (!in_run && $urandom_range(3) == 0)
            begin
                push_request(ST_RUN, 20'($urandom), 17'($urandom));
                in_run = 1;
            end
        end
        if (!in_run && $urandom_range(1))
            push_request(ST_RUN, 20'($urandom), 17'($urandom));
        push_request(ST_STOP, 20'($urandom), 17'($urandom));
    endtask

    // Starts in STOP; produces one error, after which all is ignored
    task automatic push_error(logic [2:0] code);
        int per;
        case (code)
            E_BAD_STATE: push_item(OP_REQ, 3'($urandom_range(4, 7)), 20'($urandom),
                                   17'($urandom), $urandom, 1'b0);
            E_ILLEGAL: push_request($urandom_range(1) ? ST_RUN : ST_STOP, '0, '0);
            E_ZERO_RATE:
            begin
                push_request(ST_CAL_IMU, 20'd3, '0);
                push_request(ST_CAL_CAM, 20'd5, 17'd0);
            end
            default:
            begin
                push_request(ST_CAL_IMU, '0, '0);
                push_request(ST_CAL_CAM, 20'd5, 17'd400);
                per = 1000000 / 400;
                push_event(code == E_CAM1 ? OP_CAM1 : OP_CAM2, stim_clock, 1'b1);
                push_event(code == E_CAM1 ? OP_CAM1 : OP_CAM2,
                           stim_clock + per + 1 + $urandom_range(0, 1000), 1'b0);
            end
        endcase
        repeat (3) push_noise(3'($urandom_range(0, 7)));
    endtask

    task automatic wait_idle();
        while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_pulse_width(logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_PULSE_WIDTH;
        pwdata <= {16'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        pulse_len = value;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    initial
    begin
        logic [2:0] err_pick;
        logic [15:0] pw_setting [3];
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        pw_setting[0] = 16'd1;
        pw_setting[1] = 16'hFFFF;
        pw_setting[2] = 16'($urandom_range(2, 65534));

        // Directed: ignored ops in STOP, zero IMU target, wraparound and fastest rate
        push_noise(3'd5);
        push_noise(3'd6);
        push_noise(3'd7);
        push_event(OP_IMU, 32'h1234, 1'b1);
        push_event(OP_CAM1, 32'h10, 1'b0);
        push_event(OP_TRIG, 32'hFFFF_FFF0, 1'b1);
        push_event(OP_TRIG, 32'hFFFF_FFF8, 1'b0);
        push_request(ST_CAL_IMU, 20'd0, '0);
        push_event(OP_IMU, 32'h55, 1'b0);
        push_request(ST_STOP, 20'hFFFFF, 17'h1FFFF);
        push_request(ST_CAL_IMU, 20'd2, '0);
        push_event(OP_IMU, 32'h0, 1'b0);
        push_event(OP_IMU, 32'hFFFF_FFFF, 1'b1);
        push_request(ST_CAL_CAM, 20'd1, 17'h1FFFF);
        push_event(OP_TRIG, 32'hFFFF_FFFE, 1'b1);
        push_event(OP_CAM1, 32'hFFFF_FFFE, 1'b1);
        push_event(OP_CAM1, 32'h0000_0003, 1'b0);
        push_event(OP_CAM2, 32'h100, 1'b1);
        push_event(OP_CAM2, 32'h100, 1'b0);
        push_request(ST_RUN, '0, '0);
        push_event(OP_TRIG, 32'h200, 1'b0);
        push_request(ST_STOP, '0, '0);

        // Three traffic phases, each under its own pulse width
        for (int ph = 0; ph < 3; ph++)
        begin
            wait_idle();
            write_pulse_width(pw_setting[ph]);
            sender_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 62 : 0;
            receiver_idle_pct = (ph == 0) ? 62 : (ph == 1) ? 21 : 0;
            phase_pushed = 0;
            while (phase_pushed < PHASE_ITEMS)
                push_session();
        end

        // One error at the very end since it halts the block for good
        err_pick = 3'($urandom_range(0, 4));
        push_error(err_pick);
        wait_idle();

        $display("covered %0d input transfers and %0d result transfers, 3 pulse widths,",
                 items_sent, results_seen);
        $display("closing error case %0d, %0d results left unmatched",
                 err_pick, expected_results.size());
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("camera_imu_trigger_sequencer_test OK");
        else
            $display("camera_imu_trigger_sequencer_test NOT OK");
        $finish;
    end

endmodule

>>> filelist.f
sv/cits_pkg.sv
sv/cits_datapath.sv
sv/cits_control.sv
sv/camera_imu_trigger_sequencer.sv
test/camera_imu_trigger_sequencer_test.sv
